// ===== rtl/core/cbs_pkg.sv =====
// Shared types, codes and helpers for the calorimeter bin sum block.
// No dependencies; every other file in rtl/core imports this package.
package cbs_pkg;

  localparam int SUB_SECTORS_DEF = 5;
  localparam int ETA_BINS_DEF    = 12;
  localparam int TOWERS_DEF      = 60;
  localparam int STRIPS_DEF      = 288;

  localparam int EW    = 24;
  localparam int SW    = 32;
  localparam int LANES = 4;

  localparam logic [1:0] MODE_ACC   = 2'd0;
  localparam logic [1:0] MODE_TOWER = 2'd1;
  localparam logic [1:0] MODE_STRIP = 2'd2;

  localparam logic [2:0] LAYER_POST    = 3'd3;
  localparam logic [2:0] LAYER_STRIP_U = 3'd4;
  localparam logic [2:0] LAYER_STRIP_V = 3'd5;

  localparam logic [2:0] KIND_STRIP_U = 3'd4;

  typedef struct packed {
    logic [1:0]    mode;
    logic [2:0]    layer;
    logic [2:0]    sub_sector;
    logic [3:0]    eta_bin;
    logic [8:0]    strip_number;
    logic [EW-1:0] energy;
  } cbs_in_t;

  typedef struct packed {
    logic [2:0]    hit_kind;
    logic [2:0]    out_sub_sector;
    logic [3:0]    out_eta_bin;
    logic [8:0]    out_strip;
    logic [SW-1:0] out_energy;
    logic          last;
  } cbs_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_T_LOAD,
    ST_T_SUM,
    ST_T_TOT,
    ST_S_LOAD,
    ST_EMIT
  } cbs_state_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

  function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SW] ? '1 : s[SW-1:0];
  endfunction

endpackage

// ===== rtl/core/calorimeter_bin_sum_zero_suppress.sv =====
// Top level of the calorimeter bin sum block with zero-suppressed readout.
// Depends on cbs_pkg, cbs_ram and cbs_ctrl.
//
// Usage:
//   Input: drive in_item and raise start; the transaction is taken at a clock
//   edge where start is high and busy is low. Mode 0 adds energy into one bin,
//   mode 1 reads out one tower (pre1, pre2, four-layer total, post), mode 2
//   reads out one strip (plane U, plane V). A readout zeroes the bins it reads.
//   Output: each result sits on out_item for one cycle with out_valid high;
//   the final result of a readout carries last. Results cannot be held off.
//   Config: cfg_we with cfg_wdata writes energy_threshold; write while idle.
// Sequence:
//   Accumulate: RAM read, then add and write back in the bank.
//   Tower readout: load (bin zeroed), pair sums, total, then an emit per result;
//   the total comes from two saturating adder stages. Strip readout: load (bin
//   zeroed), then an emit per result. Each result is registered and appears on
//   out_item in the cycle after its emit state.
// Reset:
//   rst_n low clears control and the threshold; after release a clearing pass
//   over every address zeroes both banks while busy stays high.
module calorimeter_bin_sum_zero_suppress #(
  parameter int SUB_SECTORS = cbs_pkg::SUB_SECTORS_DEF,
  parameter int ETA_BINS    = cbs_pkg::ETA_BINS_DEF,
  parameter int TOWERS      = cbs_pkg::TOWERS_DEF,
  parameter int STRIPS      = cbs_pkg::STRIPS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  cbs_pkg::cbs_in_t       in_item,
  output logic                   out_valid,
  output cbs_pkg::cbs_out_t      out_item,
  input  logic                   cfg_we,
  input  logic [cbs_pkg::EW-1:0] cfg_wdata
);
  import cbs_pkg::*;

  localparam int TAW = addr_w(TOWERS);
  localparam int SAW = addr_w(STRIPS);

  logic                  tw_we, tw_re, st_we, st_re;
  logic [TAW-1:0]        tw_waddr, tw_raddr;
  logic [SAW-1:0]        st_waddr, st_raddr;
  logic [LANES*SW-1:0]   tw_wdata, tw_rdata;
  logic [2*SW-1:0]       st_wdata, st_rdata;

  cbs_ctrl #(
    .SUB_SECTORS (SUB_SECTORS),
    .ETA_BINS    (ETA_BINS),
    .TOWERS      (TOWERS),
    .STRIPS      (STRIPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tw_we     (tw_we),
    .tw_waddr  (tw_waddr),
    .tw_wdata  (tw_wdata),
    .tw_re     (tw_re),
    .tw_raddr  (tw_raddr),
    .tw_rdata  (tw_rdata),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .st_re     (st_re),
    .st_raddr  (st_raddr),
    .st_rdata  (st_rdata)
  );

  cbs_ram #(
    .DEPTH (TOWERS),
    .WIDTH (LANES * SW)
  ) u_tower_ram (
    .clk   (clk),
    .we    (tw_we),
    .waddr (tw_waddr),
    .wdata (tw_wdata),
    .re    (tw_re),
    .raddr (tw_raddr),
    .rdata (tw_rdata)
  );

  cbs_ram #(
    .DEPTH (STRIPS),
    .WIDTH (2 * SW)
  ) u_strip_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

endmodule

// ===== rtl/core/cbs_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with a registered read.
// Depends on cbs_pkg for address width and default depth.
module cbs_ram #(
  parameter int DEPTH = cbs_pkg::TOWERS_DEF,
  parameter int WIDTH = cbs_pkg::LANES * cbs_pkg::SW
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [cbs_pkg::addr_w(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [cbs_pkg::addr_w(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]                    rdata
);
  import cbs_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/cbs_ctrl.sv =====
// Sequencer and datapath: decode, read-modify-write of bins, readout and emit.
// Depends on cbs_pkg; drives the tower and strip RAMs built from cbs_ram.
module cbs_ctrl #(
  parameter int SUB_SECTORS = cbs_pkg::SUB_SECTORS_DEF,
  parameter int ETA_BINS    = cbs_pkg::ETA_BINS_DEF,
  parameter int TOWERS      = cbs_pkg::TOWERS_DEF,
  parameter int STRIPS      = cbs_pkg::STRIPS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  cbs_pkg::cbs_in_t                         in_item,
  output logic                                     out_valid,
  output cbs_pkg::cbs_out_t                        out_item,
  input  logic                                     cfg_we,
  input  logic [cbs_pkg::EW-1:0]                   cfg_wdata,
  output logic                                     tw_we,
  output logic [cbs_pkg::addr_w(TOWERS)-1:0]       tw_waddr,
  output logic [cbs_pkg::LANES*cbs_pkg::SW-1:0]    tw_wdata,
  output logic                                     tw_re,
  output logic [cbs_pkg::addr_w(TOWERS)-1:0]       tw_raddr,
  input  logic [cbs_pkg::LANES*cbs_pkg::SW-1:0]    tw_rdata,
  output logic                                     st_we,
  output logic [cbs_pkg::addr_w(STRIPS)-1:0]       st_waddr,
  output logic [2*cbs_pkg::SW-1:0]                 st_wdata,
  output logic                                     st_re,
  output logic [cbs_pkg::addr_w(STRIPS)-1:0]       st_raddr,
  input  logic [2*cbs_pkg::SW-1:0]                 st_rdata
);
  import cbs_pkg::*;

  localparam int TAW  = addr_w(TOWERS);
  localparam int SAW  = addr_w(STRIPS);
  localparam int MAXD = (TOWERS > STRIPS) ? TOWERS : STRIPS;
  localparam int CW   = addr_w(MAXD);
  localparam int IW   = 11;

  cbs_state_t     state_r, state_nxt;
  logic [CW-1:0]  clr_cnt_r;
  logic [EW-1:0]  thr_r;
  cbs_in_t        item_r;
  logic [TAW-1:0] tw_idx_r;
  logic [SAW-1:0] st_idx_r;
  logic [SW-1:0]  lane_r   [LANES];
  logic [SW-1:0]  lane_nxt [LANES];
  logic [SW-1:0]  pair_r   [2];
  logic [SW-1:0]  pair_nxt [2];
  logic [3:0]     mask_r, mask_nxt;
  cbs_out_t       out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic           accept;
  logic [IW-1:0]  tw_lin, st_lin;
  logic           tw_ok, st_ok;
  logic           acc_tw, acc_st, rd_tw, rd_st;
  logic [SW-1:0]  thr_ext, total, add_in;
  logic [3:0]     pick;
  logic [1:0]     slot;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign thr_ext   = {{(SW-EW){1'b0}}, thr_r};
  assign add_in    = {{(SW-EW){1'b0}}, item_r.energy};

  assign tw_lin = IW'(in_item.sub_sector) * IW'(ETA_BINS) + IW'(in_item.eta_bin) - IW'(1);
  assign st_lin = IW'(in_item.strip_number) - IW'(1);
  assign tw_ok  = (32'(in_item.sub_sector) < SUB_SECTORS) && (in_item.eta_bin != '0) &&
                  (32'(in_item.eta_bin) <= ETA_BINS) && (32'(tw_lin) < TOWERS);
  assign st_ok  = (in_item.strip_number != '0) && (32'(in_item.strip_number) <= STRIPS);

  assign acc_tw = (in_item.mode == MODE_ACC) && (in_item.layer <= LAYER_POST) && tw_ok;
  assign acc_st = (in_item.mode == MODE_ACC) && st_ok &&
                  ((in_item.layer == LAYER_STRIP_U) || (in_item.layer == LAYER_STRIP_V));
  assign rd_tw  = (in_item.mode == MODE_TOWER) && tw_ok;
  assign rd_st  = (in_item.mode == MODE_STRIP) && st_ok;

  assign tw_re    = accept && (acc_tw || rd_tw);
  assign st_re    = accept && (acc_st || rd_st);
  assign tw_raddr = tw_lin[TAW-1:0];
  assign st_raddr = st_lin[SAW-1:0];

  assign total = sat_add(pair_r[0], pair_r[1]);

  always_comb begin
    pick = 4'b0000;
    slot = 2'd0;
    priority if (mask_r[0]) begin
      pick = 4'b0001;
      slot = 2'd0;
    end else if (mask_r[1]) begin
      pick = 4'b0010;
      slot = 2'd1;
    end else if (mask_r[2]) begin
      pick = 4'b0100;
      slot = 2'd2;
    end else if (mask_r[3]) begin
      pick = 4'b1000;
      slot = 2'd3;
    end else begin
      pick = 4'b0000;
      slot = 2'd0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == CW'(MAXD - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (acc_tw || acc_st) state_nxt = ST_ACC;
          else if (rd_tw) state_nxt = ST_T_LOAD;
          else if (rd_st) state_nxt = ST_S_LOAD;
          else state_nxt = ST_IDLE;
        end
      end
      ST_ACC:    state_nxt = ST_IDLE;
      ST_T_LOAD: state_nxt = ST_T_SUM;
      ST_T_SUM:  state_nxt = ST_T_TOT;
      ST_T_TOT:  state_nxt = (mask_nxt != '0) ? ST_EMIT : ST_IDLE;
      ST_S_LOAD: state_nxt = (mask_nxt != '0) ? ST_EMIT : ST_IDLE;
      ST_EMIT:   state_nxt = (mask_nxt != '0) ? ST_EMIT : ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    tw_we         = 1'b0;
    tw_waddr      = tw_idx_r;
    tw_wdata      = '0;
    st_we         = 1'b0;
    st_waddr      = st_idx_r;
    st_wdata      = '0;
    lane_nxt      = lane_r;
    pair_nxt      = pair_r;
    mask_nxt      = mask_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        tw_we    = (32'(clr_cnt_r) < TOWERS);
        tw_waddr = clr_cnt_r[TAW-1:0];
        st_we    = (32'(clr_cnt_r) < STRIPS);
        st_waddr = clr_cnt_r[SAW-1:0];
      end
      ST_ACC: begin
        if (item_r.layer[2]) begin
          st_we    = 1'b1;
          st_wdata = st_rdata;
          for (int i = 0; i < 2; i++) begin
            if (item_r.layer[0] == 1'(i)) begin
              st_wdata[SW*i +: SW] = sat_add(st_rdata[SW*i +: SW], add_in);
            end
          end
        end else begin
          tw_we    = 1'b1;
          tw_wdata = tw_rdata;
          for (int i = 0; i < LANES; i++) begin
            if (item_r.layer[1:0] == 2'(i)) begin
              tw_wdata[SW*i +: SW] = sat_add(tw_rdata[SW*i +: SW], add_in);
            end
          end
        end
      end
      ST_T_LOAD: begin
        tw_we = 1'b1;
        for (int i = 0; i < LANES; i++) begin
          lane_nxt[i] = tw_rdata[SW*i +: SW];
        end
      end
      ST_T_SUM: begin
        pair_nxt[0] = sat_add(lane_r[0], lane_r[1]);
        pair_nxt[1] = sat_add(lane_r[2], lane_r[3]);
      end
      ST_T_TOT: begin
        lane_nxt[2] = total;
        mask_nxt    = {lane_r[3] > thr_ext, total > thr_ext,
                       lane_r[1] > thr_ext, lane_r[0] > thr_ext};
      end
      ST_S_LOAD: begin
        st_we       = 1'b1;
        lane_nxt[0] = st_rdata[SW-1:0];
        lane_nxt[1] = st_rdata[2*SW-1:SW];
        mask_nxt    = {2'b00, st_rdata[2*SW-1:SW] > thr_ext, st_rdata[SW-1:0] > thr_ext};
      end
      ST_EMIT: begin
        mask_nxt           = mask_r & ~pick;
        out_valid_nxt      = 1'b1;
        out_nxt.out_energy = lane_r[slot];
        out_nxt.last       = (mask_nxt == '0);
        if (item_r.mode == MODE_STRIP) begin
          out_nxt.hit_kind       = KIND_STRIP_U + 3'(slot);
          out_nxt.out_sub_sector = '0;
          out_nxt.out_eta_bin    = '0;
          out_nxt.out_strip      = item_r.strip_number;
        end else begin
          out_nxt.hit_kind       = 3'(slot);
          out_nxt.out_sub_sector = item_r.sub_sector;
          out_nxt.out_eta_bin    = item_r.eta_bin;
          out_nxt.out_strip      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      thr_r       <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + CW'(1);
      if (cfg_we) thr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r   <= in_item;
      tw_idx_r <= tw_lin[TAW-1:0];
      st_idx_r <= st_lin[SAW-1:0];
    end
    lane_r <= lane_nxt;
    pair_r <= pair_nxt;
    out_r  <= out_nxt;
  end

  a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_EMIT))
    else $error("result strobe without emit cycle");

  a_single_bank_write: assert property (@(posedge clk) disable iff (!rst_n)
    (tw_we && st_we) |-> (state_r == ST_CLEAR))
    else $error("both banks written outside clearing pass");

  a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (mask_r != '0))
    else $error("emit state with empty mask");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |=> !out_valid_r)
    else $error("result after final transaction of readout");

endmodule
